// ===== hdl/scc_pkg.sv =====
package scc_pkg;

    // Largest number of vertices; vertex numbers are six bits wide.
    localparam int MAX_VERTICES = 32;

    // Input command codes.
    localparam logic [1:0] CMD_ADD     = 2'd0;
    localparam logic [1:0] CMD_ADD_RUN = 2'd1;
    localparam logic [1:0] CMD_RUN     = 2'd2;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FWD_START,
        ST_FWD_SCAN,
        ST_REV_START,
        ST_REV_SCAN,
        ST_OUT_COUNT,
        ST_OUT_FIND,
        ST_OUT_MEMBER,
        ST_CLEAR
    } scc_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic store_edge;
        logic run_init;
        logic fwd_next_root;
        logic fwd_step;
        logic rev_next_root;
        logic rev_step;
        logic out_count;
        logic out_find;
        logic out_member;
        logic clear;
    } scc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic fwd_roots_done;
        logic stack_empty;
        logic rev_roots_done;
        logic find_done;
        logic member_done;
        logic out_free;
    } scc_stat_t;

endpackage

// ===== hdl/scc_ctrl.sv =====
module scc_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  logic [1:0]           in_cmd,
    input  scc_pkg::scc_stat_t   stat,
    output logic                 in_ready,
    output scc_pkg::scc_cmd_t    cmd
);

    scc_pkg::scc_state_t state_reg, state_next;
    logic take;

    assign take = in_valid && in_ready;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= scc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            scc_pkg::ST_IDLE: begin
                if (take && (in_cmd == scc_pkg::CMD_ADD_RUN || in_cmd == scc_pkg::CMD_RUN))
                    state_next = scc_pkg::ST_FWD_START;
            end
            scc_pkg::ST_FWD_START: begin
                if (stat.fwd_roots_done) state_next = scc_pkg::ST_REV_START;
                else state_next = scc_pkg::ST_FWD_SCAN;
            end
            scc_pkg::ST_FWD_SCAN: begin
                if (stat.stack_empty) state_next = scc_pkg::ST_FWD_START;
            end
            scc_pkg::ST_REV_START: begin
                if (stat.rev_roots_done) state_next = scc_pkg::ST_OUT_COUNT;
                else state_next = scc_pkg::ST_REV_SCAN;
            end
            scc_pkg::ST_REV_SCAN: begin
                if (stat.stack_empty) state_next = scc_pkg::ST_REV_START;
            end
            scc_pkg::ST_OUT_COUNT: begin
                if (stat.out_free) state_next = scc_pkg::ST_OUT_FIND;
            end
            scc_pkg::ST_OUT_FIND: begin
                if (stat.find_done) state_next = scc_pkg::ST_CLEAR;
                else state_next = scc_pkg::ST_OUT_MEMBER;
            end
            scc_pkg::ST_OUT_MEMBER: begin
                if (stat.member_done) state_next = scc_pkg::ST_OUT_FIND;
            end
            scc_pkg::ST_CLEAR: begin
                state_next = scc_pkg::ST_IDLE;
            end
            default: state_next = scc_pkg::ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        cmd = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            scc_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                cmd.store_edge = in_valid &&
                    (in_cmd == scc_pkg::CMD_ADD || in_cmd == scc_pkg::CMD_ADD_RUN);
                cmd.run_init = in_valid &&
                    (in_cmd == scc_pkg::CMD_ADD_RUN || in_cmd == scc_pkg::CMD_RUN);
            end
            scc_pkg::ST_FWD_START: cmd.fwd_next_root = 1'b1;
            scc_pkg::ST_FWD_SCAN:  cmd.fwd_step = 1'b1;
            scc_pkg::ST_REV_START: cmd.rev_next_root = 1'b1;
            scc_pkg::ST_REV_SCAN:  cmd.rev_step = 1'b1;
            scc_pkg::ST_OUT_COUNT: cmd.out_count = 1'b1;
            scc_pkg::ST_OUT_FIND:  cmd.out_find = 1'b1;
            scc_pkg::ST_OUT_MEMBER: cmd.out_member = 1'b1;
            scc_pkg::ST_CLEAR:     cmd.clear = 1'b1;
            default: ;
        endcase
    end

endmodule

// ===== hdl/scc_dp.sv =====
module scc_dp #(
    parameter int MAX_EDGES    = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [5:0]          vcount,
    input  logic [5:0]          in_from,
    input  logic [5:0]          in_to,
    input  scc_pkg::scc_cmd_t   cmd,
    output scc_pkg::scc_stat_t  stat,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_data,
    output logic                out_user,
    output logic                out_last
);

    localparam int MAX_VERTICES = scc_pkg::MAX_VERTICES;
    localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CW = $clog2(MAX_EDGES + 1);
    localparam int VW = $clog2(MAX_VERTICES);
    localparam int NV = MAX_VERTICES + 1;

    // Edge memories and their registered read ports.
    logic [5:0] tail_mem [MAX_EDGES];
    logic [5:0] head_mem [MAX_EDGES];
    logic [5:0] rd_tail_reg, rd_head_reg;
    logic [CW-1:0] edges_reg;
    logic          drop_reg;
    logic [5:0]    n_eff;

    // Per-vertex flags and ids in flip-flops, cleared at once. Ids and
    // emitted flags are held at index vertex - 1.
    logic [NV-1:0] visited_reg;
    logic [5:0]    comp_reg [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] emitted_reg;
    logic [5:0]    finish_reg [MAX_VERTICES];
    logic [5:0]    fcount_reg;

    // Walk stack: the top is cached in registers.
    logic [5:0]    stk_v [MAX_VERTICES];
    logic [CW-1:0] stk_k [MAX_VERTICES];
    logic [6:0]    top_reg;
    logic [5:0]    cur_v_reg;
    logic [CW-1:0] cur_k_reg;
    logic          rd_ok_reg;      // read data belongs to cur_k_reg

    logic [6:0]    root_reg;       // next forward root, or finish index
    logic [5:0]    count_reg;
    logic [6:0]    scan_v_reg, memb_u_reg;
    logic [5:0]    cid_reg;

    // Output register.
    logic          ov_reg;
    logic [7:0]    od_reg;
    logic          ou_reg, ol_reg;

    assign n_eff = (vcount > 6'(MAX_VERTICES)) ? 6'(MAX_VERTICES) : vcount;
    assign out_valid = ov_reg;
    assign out_data  = od_reg;
    assign out_user  = ou_reg;
    assign out_last  = ol_reg;
    assign stat.out_free = !ov_reg || out_ready;

    // Edge acceptance check for the incoming edge.
    logic edge_ok;
    assign edge_ok = in_from != 6'd0 && in_from <= n_eff && in_to != 6'd0 &&
                     in_to <= n_eff && edges_reg < CW'(MAX_EDGES);

    // Edge memory write and read.
    always_ff @(posedge aclk) begin
        if (cmd.store_edge && edge_ok) begin
            tail_mem[edges_reg[EW-1:0]] <= in_from;
            head_mem[edges_reg[EW-1:0]] <= in_to;
        end
        rd_tail_reg <= tail_mem[cur_k_reg[EW-1:0]];
        rd_head_reg <= head_mem[cur_k_reg[EW-1:0]];
    end

    // Scan logic: examine the edge at cur_k_reg for the top vertex.
    logic          scan_active, fwd, hit;
    logic [5:0]    nb, own;
    logic [VW-1:0] nb_i;
    assign fwd = cmd.fwd_step;
    assign scan_active = cmd.fwd_step || cmd.rev_step;
    assign nb  = fwd ? rd_head_reg : rd_tail_reg;
    assign own = fwd ? rd_tail_reg : rd_head_reg;
    assign nb_i = VW'(nb - 6'd1);
    assign hit = rd_ok_reg && own == cur_v_reg && nb != 6'd0 && nb <= n_eff &&
                 own <= n_eff &&
                 (fwd ? !visited_reg[nb[VW:0]] : comp_reg[nb_i] == 6'd0);
    assign stat.stack_empty = top_reg == 7'd0;

    // Root selection.
    logic [5:0]    fin_r;
    logic [VW-1:0] fin_i;
    assign fin_r = finish_reg[VW'(root_reg - 7'd1)];
    assign fin_i = VW'(fin_r - 6'd1);
    assign stat.fwd_roots_done = root_reg > {1'b0, n_eff};
    assign stat.rev_roots_done = root_reg == 7'd0;

    // Output scan status.
    logic [VW-1:0] scan_i, memb_i;
    assign scan_i = VW'(scan_v_reg - 7'd1);
    assign memb_i = VW'(memb_u_reg - 7'd1);
    assign stat.find_done   = scan_v_reg > {1'b0, n_eff};
    assign stat.member_done = memb_u_reg > {1'b0, n_eff};

    // Last member lookahead: any later vertex in the current component.
    logic later;
    always_comb begin
        later = 1'b0;
        for (int i = 0; i < MAX_VERTICES; i++)
            if (7'(i + 1) > memb_u_reg && 6'(i + 1) <= n_eff && comp_reg[i] == cid_reg)
                later = 1'b1;
    end
    // Another component still waits while some assigned vertex has not been
    // emitted; the member going out now does not count.
    logic more_comp;
    always_comb begin
        more_comp = 1'b0;
        for (int i = 0; i < MAX_VERTICES; i++)
            if (6'(i + 1) <= n_eff && comp_reg[i] != 6'd0 && !emitted_reg[i] &&
                7'(i + 1) != memb_u_reg)
                more_comp = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            edges_reg  <= '0;
            drop_reg   <= 1'b0;
            visited_reg <= '0;
            emitted_reg <= '0;
            fcount_reg <= '0;
            top_reg    <= '0;
            ov_reg     <= 1'b0;
            rd_ok_reg  <= 1'b0;
            root_reg   <= '0;
            count_reg  <= '0;
            for (int i = 0; i < MAX_VERTICES; i++) comp_reg[i] <= '0;
        end else begin
            if (ov_reg && out_ready) ov_reg <= 1'b0;
            rd_ok_reg <= 1'b0;

            if (cmd.store_edge) begin
                if (edge_ok) edges_reg <= edges_reg + CW'(1);
                else drop_reg <= 1'b1;
            end
            if (cmd.run_init) begin
                root_reg <= 7'd1;
            end

            // Forward roots.
            if (cmd.fwd_next_root) begin
                if (!stat.fwd_roots_done) begin
                    root_reg <= root_reg + 7'd1;
                    if (!visited_reg[root_reg[VW:0]]) begin
                        visited_reg[root_reg[VW:0]] <= 1'b1;
                        cur_v_reg <= root_reg[5:0];
                        cur_k_reg <= '0;
                        top_reg <= 7'd1;
                    end
                end else begin
                    root_reg <= {1'b0, fcount_reg};
                end
            end

            // Reverse roots, last finished first.
            if (cmd.rev_next_root && !stat.rev_roots_done) begin
                root_reg <= root_reg - 7'd1;
                if (fin_r != 6'd0 && fin_r <= n_eff && comp_reg[fin_i] == 6'd0) begin
                    comp_reg[fin_i] <= count_reg + 6'd1;
                    count_reg <= count_reg + 6'd1;
                    cur_v_reg <= fin_r;
                    cur_k_reg <= '0;
                    top_reg <= 7'd1;
                end
            end

            // Edge scan: issue a read of the edge, then examine the registered read data.
            if (scan_active && top_reg != 7'd0) begin
                if (!rd_ok_reg) begin
                    if (cur_k_reg >= edges_reg) begin
                        // No edges left for this vertex: pop.
                        if (fwd && fcount_reg < 6'(MAX_VERTICES)) begin
                            finish_reg[VW'(fcount_reg)] <= cur_v_reg;
                            fcount_reg <= fcount_reg + 6'd1;
                        end
                        top_reg <= top_reg - 7'd1;
                        if (top_reg > 7'd1) begin
                            cur_v_reg <= stk_v[VW'(top_reg - 7'd2)];
                            cur_k_reg <= stk_k[VW'(top_reg - 7'd2)];
                        end
                    end else begin
                        rd_ok_reg <= 1'b1;
                    end
                end else if (hit) begin
                    if (fwd) visited_reg[nb[VW:0]] <= 1'b1;
                    else comp_reg[nb_i] <= count_reg;
                    if (top_reg < 7'(MAX_VERTICES)) begin
                        stk_v[VW'(top_reg - 7'd1)] <= cur_v_reg;
                        stk_k[VW'(top_reg - 7'd1)] <= cur_k_reg + CW'(1);
                        top_reg <= top_reg + 7'd1;
                        cur_v_reg <= nb;
                        cur_k_reg <= '0;
                    end else begin
                        cur_k_reg <= cur_k_reg + CW'(1);
                    end
                end else begin
                    cur_k_reg <= cur_k_reg + CW'(1);
                end
            end

            // Count result.
            if (cmd.out_count && stat.out_free) begin
                ov_reg <= 1'b1;
                od_reg <= {drop_reg, 1'b0, count_reg};
                ou_reg <= 1'b0;
                ol_reg <= n_eff == 6'd0;
                scan_v_reg <= 7'd1;
                cid_reg <= '0;
            end

            // Find the next component's smallest member: the lowest vertex
            // not emitted yet.
            if (cmd.out_find && !stat.find_done) begin
                scan_v_reg <= scan_v_reg + 7'd1;
                if (!emitted_reg[scan_i] && comp_reg[scan_i] != 6'd0) begin
                    cid_reg <= comp_reg[scan_i];
                    memb_u_reg <= scan_v_reg;
                end else begin
                    memb_u_reg <= 7'(MAX_VERTICES + 1);
                end
            end

            // Emit members of the current component.
            if (cmd.out_member && !stat.member_done && stat.out_free) begin
                memb_u_reg <= memb_u_reg + 7'd1;
                if (comp_reg[memb_i] == cid_reg) begin
                    emitted_reg[memb_i] <= 1'b1;
                    ov_reg <= 1'b1;
                    od_reg <= {drop_reg, !later, memb_u_reg[5:0]};
                    ou_reg <= 1'b1;
                    ol_reg <= !later && !more_comp;
                end
            end

            if (cmd.clear) begin
                edges_reg <= '0;
                drop_reg <= 1'b0;
                visited_reg <= '0;
                emitted_reg <= '0;
                fcount_reg <= '0;
                count_reg <= '0;
                for (int i = 0; i < MAX_VERTICES; i++) comp_reg[i] <= '0;
            end
        end
    end

endmodule

// ===== hdl/strongly_connected_components_top.sv =====
// Channel   Dir  tdata (low bit up)                 tuser / tlast
// s_axis    in   cmd[1:0], from[7:2], to[13:8]      -
// m_axis    out  value[5:0], comp_end[6], drop[7]   tuser = kind, tlast = last
// cfg       in   vertex_count[5:0]                  -
// Edge transfers can follow back to back. During a run no input is taken:
// each root is started, each examined edge is read, then compared, and a
// vertex is popped once its edges are used up. Output sends the component
// count, then passes over each vertex that starts no component and, per
// component, walks from its smallest member up to vertex_count emitting
// members; a clearing state ends the run. Reset is synchronous on aresetn
// low and sets vertex_count to 32. An output stall holds the result register.
module strongly_connected_components_top #(
    parameter int MAX_EDGES    = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [5:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // cmd, from_vertex, to_vertex
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // value, component_end, edges_dropped
    output logic        m_tuser,   // kind
    output logic        m_tlast
);

    logic [5:0] vcount_reg;
    scc_pkg::scc_cmd_t  cmd;
    scc_pkg::scc_stat_t stat;

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) vcount_reg <= 6'd32;
        else if (cfg_we) vcount_reg <= cfg_wdata;
    end

    scc_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid),
        .in_cmd(s_tdata[1:0]), .stat(stat), .in_ready(s_tready), .cmd(cmd)
    );

    scc_dp #(.MAX_EDGES(MAX_EDGES)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .vcount(vcount_reg),
        .in_from(s_tdata[7:2]), .in_to(s_tdata[13:8]), .cmd(cmd), .stat(stat),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_data(m_tdata),
        .out_user(m_tuser), .out_last(m_tlast)
    );

endmodule
